// ===== hw/rtl/pctd_pkg.sv =====
// Shared widths, codes and result type for the prefix code tree decoder.
package pctd_pkg;

  localparam int NODE_COUNT_DEF   = 512;
  localparam int MAX_CODE_LEN_DEF = 32;

  localparam int SYM_W    = 8;
  localparam int CODE_W   = 32;
  localparam int LEN_IN_W = 6;

  localparam logic KIND_LOAD   = 1'b0;
  localparam logic KIND_DECODE = 1'b1;

  typedef struct packed {
    logic [SYM_W-1:0] sym;
    logic             failed;
  } res_t;

endpackage

// ===== hw/rtl/pctd_node_mem.sv =====
// Node store: root node in flops, all other nodes in a one-port-read/one-port-write RAM.
module pctd_node_mem #(
  parameter int NODE_COUNT = pctd_pkg::NODE_COUNT_DEF,
  localparam int IDX_W = $clog2(NODE_COUNT)
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     rd_en,
  input  logic [IDX_W-1:0]         rd_addr,
  output logic [pctd_pkg::SYM_W-1:0] rd_sym,
  output logic [IDX_W-1:0]         rd_left,
  output logic [IDX_W-1:0]         rd_right,
  input  logic                     wr_en,
  input  logic [IDX_W-1:0]         wr_addr,
  input  logic [pctd_pkg::SYM_W-1:0] wr_sym,
  input  logic [IDX_W-1:0]         wr_left,
  input  logic [IDX_W-1:0]         wr_right
);

  localparam int WORD_W = pctd_pkg::SYM_W + 2 * IDX_W;

  logic [WORD_W-1:0] mem [NODE_COUNT];
  logic [WORD_W-1:0] q_r;
  logic [WORD_W-1:0] root_r;
  logic              rd_root_r;
  logic [WORD_W-1:0] rd_word;

  // Nodes other than the root are always written at allocation before any read.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= {wr_sym, wr_left, wr_right};
    end
    if (rd_en) begin
      q_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      root_r    <= '0;
      rd_root_r <= 1'b1;
    end else begin
      if (wr_en && wr_addr == '0) begin
        root_r <= {wr_sym, wr_left, wr_right};
      end
      if (rd_en) begin
        rd_root_r <= (rd_addr == '0);
      end
    end
  end

  assign rd_word  = rd_root_r ? root_r : q_r;
  assign rd_sym   = rd_word[WORD_W-1 -: pctd_pkg::SYM_W];
  assign rd_left  = rd_word[2*IDX_W-1 -: IDX_W];
  assign rd_right = rd_word[IDX_W-1:0];

endmodule

// ===== hw/rtl/pctd_seq.sv =====
// Sequencer: tree walk and node allocation for loads, cursor stepping for decodes.
module pctd_seq #(
  parameter int NODE_COUNT   = pctd_pkg::NODE_COUNT_DEF,
  parameter int MAX_CODE_LEN = pctd_pkg::MAX_CODE_LEN_DEF,
  localparam int IDX_W = $clog2(NODE_COUNT)
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_kind,
  input  logic [pctd_pkg::SYM_W-1:0]    in_symbol,
  input  logic [pctd_pkg::CODE_W-1:0]   in_code_bits,
  input  logic [pctd_pkg::LEN_IN_W-1:0] in_code_length,
  input  logic                          in_bit_req,
  output logic                          rd_en,
  output logic [IDX_W-1:0]              rd_addr,
  input  logic [pctd_pkg::SYM_W-1:0]    rd_sym,
  input  logic [IDX_W-1:0]              rd_left,
  input  logic [IDX_W-1:0]              rd_right,
  output logic                          wr_en,
  output logic [IDX_W-1:0]              wr_addr,
  output logic [pctd_pkg::SYM_W-1:0]    wr_sym,
  output logic [IDX_W-1:0]              wr_left,
  output logic [IDX_W-1:0]              wr_right,
  output logic                          res_valid,
  input  logic                          res_ready,
  output pctd_pkg::res_t                res
);

  localparam int FREE_W = $clog2(NODE_COUNT + 1);
  localparam int LEN_W  = $clog2(MAX_CODE_LEN + 1);
  localparam int POS_W  = (LEN_W > 6) ? LEN_W : 6;
  localparam int CMP_W  = (FREE_W > LEN_W) ? FREE_W : LEN_W;
  localparam int CLMP_W = 7;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_WALK  = 6'b000010,
    S_ALLOC = 6'b000100,
    S_DEC1  = 6'b001000,
    S_DEC2  = 6'b010000,
    S_EMIT  = 6'b100000
  } state_t;

  state_t                        state_r, state_nxt;
  logic [pctd_pkg::SYM_W-1:0]    sym_r, sym_nxt;
  logic [pctd_pkg::CODE_W-1:0]   bits_r, bits_nxt;
  logic [LEN_W-1:0]              len_r, len_nxt;
  logic                          bit_r, bit_nxt;
  logic [LEN_W-1:0]              depth_r, depth_nxt;
  logic [IDX_W-1:0]              node_r, node_nxt;
  logic [pctd_pkg::SYM_W-1:0]    ent_sym_r, ent_sym_nxt;
  logic [IDX_W-1:0]              ent_left_r, ent_left_nxt;
  logic [IDX_W-1:0]              ent_right_r, ent_right_nxt;
  logic [FREE_W-1:0]             free_r, free_nxt;
  logic [IDX_W-1:0]              cursor_r, cursor_nxt;
  pctd_pkg::res_t                res_r, res_nxt;

  logic [LEN_W-1:0]  pos;
  logic [POS_W-1:0]  pos_ext;
  logic              code_bit;
  logic [IDX_W-1:0]  walk_child;
  logic [IDX_W-1:0]  dec_child;
  logic              rd_leaf;
  logic [CMP_W-1:0]  need;
  logic [CMP_W-1:0]  avail;
  logic              no_room;
  logic [IDX_W-1:0]  new_idx;
  logic [LEN_W-1:0]  len_clamped;
  logic              leaf_chk;

  // First code bit sits at position len-1; positions past the code word read as zero.
  assign pos      = len_r - depth_r - LEN_W'(1);
  assign pos_ext  = POS_W'(pos);
  assign code_bit = (pos_ext < POS_W'(pctd_pkg::CODE_W)) ? bits_r[pos_ext[4:0]] : 1'b0;

  assign walk_child = code_bit ? rd_right : rd_left;
  assign dec_child  = bit_r ? rd_right : rd_left;
  assign rd_leaf    = (rd_left == '0) && (rd_right == '0);
  assign need       = CMP_W'(len_r - depth_r);
  assign avail      = CMP_W'(NODE_COUNT) - CMP_W'(free_r);
  assign no_room    = need > avail;
  assign new_idx    = free_r[IDX_W-1:0];

  assign len_clamped = (CLMP_W'(in_code_length) > CLMP_W'(MAX_CODE_LEN)) ?
                       LEN_W'(MAX_CODE_LEN) : LEN_W'(in_code_length);

  assign in_stall = (state_r != S_IDLE);
  assign res      = res_r;

  always_comb begin
    state_nxt     = state_r;
    sym_nxt       = sym_r;
    bits_nxt      = bits_r;
    len_nxt       = len_r;
    bit_nxt       = bit_r;
    depth_nxt     = depth_r;
    node_nxt      = node_r;
    ent_sym_nxt   = ent_sym_r;
    ent_left_nxt  = ent_left_r;
    ent_right_nxt = ent_right_r;
    free_nxt      = free_r;
    cursor_nxt    = cursor_r;
    res_nxt       = res_r;
    rd_en         = 1'b0;
    rd_addr       = node_r;
    wr_en         = 1'b0;
    wr_addr       = node_r;
    wr_sym        = ent_sym_r;
    wr_left       = ent_left_r;
    wr_right      = ent_right_r;
    res_valid     = 1'b0;
    leaf_chk      = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_kind == pctd_pkg::KIND_LOAD) begin
            sym_nxt   = in_symbol;
            bits_nxt  = in_code_bits;
            len_nxt   = len_clamped;
            depth_nxt = '0;
            node_nxt  = '0;
            rd_en     = 1'b1;
            rd_addr   = '0;
            state_nxt = S_WALK;
          end else begin
            bit_nxt   = in_bit_req;
            node_nxt  = cursor_r;
            rd_en     = 1'b1;
            rd_addr   = cursor_r;
            state_nxt = S_DEC1;
          end
        end
      end
      S_WALK: begin
        // Follow existing children one node per cycle, then check room for the rest.
        if (depth_r != len_r && walk_child != '0) begin
          node_nxt  = walk_child;
          depth_nxt = depth_r + LEN_W'(1);
          rd_en     = 1'b1;
          rd_addr   = walk_child;
        end else if (no_room) begin
          res_nxt.sym    = '0;
          res_nxt.failed = 1'b1;
          state_nxt      = S_EMIT;
        end else begin
          ent_sym_nxt   = rd_sym;
          ent_left_nxt  = rd_left;
          ent_right_nxt = rd_right;
          state_nxt     = S_ALLOC;
        end
      end
      S_ALLOC: begin
        // Link one fresh node per cycle; the held parent entry is written back with it.
        wr_en = 1'b1;
        if (depth_r == len_r) begin
          wr_sym    = sym_r;
          state_nxt = S_IDLE;
        end else begin
          if (code_bit) begin
            wr_right = new_idx;
          end else begin
            wr_left = new_idx;
          end
          free_nxt      = free_r + FREE_W'(1);
          node_nxt      = new_idx;
          ent_sym_nxt   = '0;
          ent_left_nxt  = '0;
          ent_right_nxt = '0;
          depth_nxt     = depth_r + LEN_W'(1);
        end
      end
      S_DEC1: begin
        if (dec_child != '0) begin
          node_nxt  = dec_child;
          rd_en     = 1'b1;
          rd_addr   = dec_child;
          state_nxt = S_DEC2;
        end else begin
          leaf_chk = 1'b1;
        end
      end
      S_DEC2: begin
        leaf_chk = 1'b1;
      end
      S_EMIT: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (leaf_chk) begin
      if (rd_leaf) begin
        res_nxt.sym    = rd_sym;
        res_nxt.failed = 1'b0;
        cursor_nxt     = '0;
        state_nxt      = S_EMIT;
      end else begin
        cursor_nxt = node_r;
        state_nxt  = S_IDLE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      free_r   <= FREE_W'(1);
      cursor_r <= '0;
    end else begin
      state_r  <= state_nxt;
      free_r   <= free_nxt;
      cursor_r <= cursor_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sym_r       <= sym_nxt;
    bits_r      <= bits_nxt;
    len_r       <= len_nxt;
    bit_r       <= bit_nxt;
    depth_r     <= depth_nxt;
    node_r      <= node_nxt;
    ent_sym_r   <= ent_sym_nxt;
    ent_left_r  <= ent_left_nxt;
    ent_right_r <= ent_right_nxt;
    res_r       <= res_nxt;
  end

endmodule

// ===== hw/rtl/prefix_code_tree_decoder_unit.sv =====
// Prefix code (Huffman) tree decoder: sequencer, node store and output register.
// One item at a time; the sequencer and the single read port of the node store set the rate.
// Load: one store read per tree level walked, one write per new node and one final symbol
//   write; a rejected load ends after the walk and returns a failed result.
// Decode bit: reads the cursor node, then its chosen child; a leaf emits its symbol as a result.
//   A result beat waits while the output register holds an unaccepted beat.
// Synchronous active-low reset empties the tree at once (root in flops, fill count for the rest).
module prefix_code_tree_decoder_unit #(
  parameter int NODE_COUNT   = pctd_pkg::NODE_COUNT_DEF,
  parameter int MAX_CODE_LEN = pctd_pkg::MAX_CODE_LEN_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_kind,
  input  logic [pctd_pkg::SYM_W-1:0]    in_symbol,
  input  logic [pctd_pkg::CODE_W-1:0]   in_code_bits,
  input  logic [pctd_pkg::LEN_IN_W-1:0] in_code_length,
  input  logic                          in_bit_req,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [pctd_pkg::SYM_W-1:0]    out_symbol_out,
  output logic                          out_load_failed
);

  localparam int IDX_W = $clog2(NODE_COUNT);

  logic                       rd_en;
  logic [IDX_W-1:0]           rd_addr;
  logic [pctd_pkg::SYM_W-1:0] rd_sym;
  logic [IDX_W-1:0]           rd_left;
  logic [IDX_W-1:0]           rd_right;
  logic                       wr_en;
  logic [IDX_W-1:0]           wr_addr;
  logic [pctd_pkg::SYM_W-1:0] wr_sym;
  logic [IDX_W-1:0]           wr_left;
  logic [IDX_W-1:0]           wr_right;
  logic                       res_valid;
  logic                       res_ready;
  pctd_pkg::res_t             res;
  logic                       out_valid_r;
  pctd_pkg::res_t             out_res_r;

  pctd_seq #(
    .NODE_COUNT   (NODE_COUNT),
    .MAX_CODE_LEN (MAX_CODE_LEN)
  ) u_seq (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_kind        (in_kind),
    .in_symbol      (in_symbol),
    .in_code_bits   (in_code_bits),
    .in_code_length (in_code_length),
    .in_bit_req     (in_bit_req),
    .rd_en          (rd_en),
    .rd_addr        (rd_addr),
    .rd_sym         (rd_sym),
    .rd_left        (rd_left),
    .rd_right       (rd_right),
    .wr_en          (wr_en),
    .wr_addr        (wr_addr),
    .wr_sym         (wr_sym),
    .wr_left        (wr_left),
    .wr_right       (wr_right),
    .res_valid      (res_valid),
    .res_ready      (res_ready),
    .res            (res)
  );

  pctd_node_mem #(
    .NODE_COUNT (NODE_COUNT)
  ) u_mem (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .rd_sym   (rd_sym),
    .rd_left  (rd_left),
    .rd_right (rd_right),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_sym   (wr_sym),
    .wr_left  (wr_left),
    .wr_right (wr_right)
  );

  // Output register: refill whenever the held beat is gone or being taken.
  assign res_ready = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_res_r <= res;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_symbol_out  = out_res_r.sym;
  assign out_load_failed = out_res_r.failed;

endmodule

// ===== hw/rtl/pctd_chk.sv =====
// Port-level checks for the prefix code tree decoder, bound to the top level.
module pctd_chk (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_stall,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic [pctd_pkg::SYM_W-1:0] out_symbol_out,
  input logic                       out_load_failed
);

  // A rejected load carries a zero symbol.
  a_fail_sym_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_load_failed |-> out_symbol_out == '0)
    else $error("rejected load beat with nonzero symbol");

  // Every accepted beat keeps the block busy for at least the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken on back-to-back cycles");

  // A new result only appears while an item is in flight.
  a_result_from_item: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result beat without an item in progress");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_symbol_out) && $stable(out_load_failed))
    else $error("stalled result beat changed");

endmodule

bind prefix_code_tree_decoder_unit pctd_chk u_pctd_chk (.*);
